[hw/rtl/hse_pkg.sv]
// Shared types and constants of the histogram statistics engine.
`timescale 1ns / 1ps

package hse_pkg;

    // Result kinds
    localparam logic [1:0] KIND_NOTICE  = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_MODE    = 2'd2;

    // Register indexes
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    localparam logic [7:0] RANGE_LOW_RST  = 8'd50;
    localparam logic [7:0] RANGE_HIGH_RST = 8'd113;

    localparam int          TOTAL_W   = 22;
    localparam logic [21:0] TOTAL_MAX = 22'h3FFFFF;
    localparam int          MEAN_W    = 16;
    localparam logic [3:0]  DIV_LAST  = 4'd15;

    // Controller to datapath commands
    typedef struct packed {
        logic rd_sample;
        logic rd_bin;
        logic bump;
        logic notice;
        logic clr_acc;
        logic mul;
        logic acc1;
        logic rank_init;
        logic acc2;
        logic div_start;
        logic div_step;
        logic emit_sum;
        logic p3_step;
        logic clear_bins;
    } hse_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_range;
        logic nb_zero;
        logic last_bin;
        logic total_zero;
        logic single_mode;
        logic p3_emit;
        logic p3_last;
        logic out_free;
    } hse_stat_t;

endpackage

[hw/rtl/hse_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module hse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hse_ctrl.sv]
// Sequencer for sample updates and the end-of-set report walk.
`timescale 1ns / 1ps

module hse_ctrl #(
    parameter int BINS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_last,
    output logic                    in_ready,
    input  hse_pkg::hse_stat_t      stat,
    output hse_pkg::hse_cmd_t       cmd,
    output logic [$clog2(BINS)-1:0] bin
);

    localparam int IDX_W = $clog2(BINS);

    typedef enum logic [3:0] {
        S_IDLE, S_BUMP, S_P1_RD, S_P1_MUL, S_P1_ACC, S_CHK, S_EMPTY,
        S_P2_RD, S_P2_ACC, S_DIV_START, S_DIV, S_SUM, S_P3_RD, S_P3_CHK, S_CLR
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] bin_reg, bin_next;
    logic [3:0]       div_reg, div_next;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;
    assign bin      = bin_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        div_next   = div_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_last)
                    begin
                        cmd.clr_acc = 1'b1;
                        bin_next    = '0;
                        state_next  = stat.nb_zero ? S_CHK : S_P1_RD;
                    end
                    else if (stat.in_range)
                    begin
                        cmd.rd_sample = 1'b1;
                        state_next    = S_BUMP;
                    end
                    else
                    begin
                        cmd.notice = 1'b1;
                    end
                end
            end
            S_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = S_IDLE;
            end
            S_P1_RD:
            begin
                cmd.rd_bin = 1'b1;
                state_next = S_P1_MUL;
            end
            S_P1_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_P1_ACC;
            end
            S_P1_ACC:
            begin
                cmd.acc1 = 1'b1;
                if (stat.last_bin)
                begin
                    bin_next   = '0;
                    state_next = S_CHK;
                end
                else
                begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = S_P1_RD;
                end
            end
            S_CHK:
            begin
                cmd.rank_init = 1'b1;
                bin_next      = '0;
                state_next    = stat.total_zero ? S_EMPTY : S_P2_RD;
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_sum = 1'b1;
                    state_next   = S_CLR;
                end
            end
            S_P2_RD:
            begin
                cmd.rd_bin = 1'b1;
                state_next = S_P2_ACC;
            end
            S_P2_ACC:
            begin
                cmd.acc2 = 1'b1;
                if (stat.last_bin)
                begin
                    bin_next   = '0;
                    state_next = S_DIV_START;
                end
                else
                begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = S_P2_RD;
                end
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                div_next      = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_next     = div_reg + 1'b1;
                if (div_reg == hse_pkg::DIV_LAST)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_sum = 1'b1;
                    bin_next     = '0;
                    state_next   = stat.single_mode ? S_CLR : S_P3_RD;
                end
            end
            S_P3_RD:
            begin
                cmd.rd_bin = 1'b1;
                state_next = S_P3_CHK;
            end
            S_P3_CHK:
            begin
                if (!stat.p3_emit || stat.out_free)
                begin
                    cmd.p3_step = 1'b1;
                    bin_next    = bin_reg + 1'b1;
                    state_next  = stat.p3_last ? S_CLR : S_P3_RD;
                end
            end
            S_CLR:
            begin
                cmd.clear_bins = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bin_reg   <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            div_reg   <= div_next;
        end
    end

endmodule

[hw/rtl/hse_dp.sv]
// Datapath: bin memory, accumulators, median search, mean divider, result register.
`timescale 1ns / 1ps

module hse_dp #(
    parameter int BINS       = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              range_low,
    input  logic [7:0]              range_high,
    input  logic [7:0]              sample,
    input  hse_pkg::hse_cmd_t       cmd,
    input  logic [$clog2(BINS)-1:0] bin,
    output hse_pkg::hse_stat_t      stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              out_kind,
    output logic [55:0]             out_data,
    output logic                    out_last
);

    localparam int IDX_W = $clog2(BINS);
    localparam int NB_W  = IDX_W + 1;
    localparam int TOT_W = COUNT_BITS + IDX_W;
    localparam int WS_W  = TOT_W + 8;
    localparam int PR_W  = COUNT_BITS + 8;
    localparam int SAT_W = (TOT_W > hse_pkg::TOTAL_W) ? TOT_W : hse_pkg::TOTAL_W;

    // Bin storage
    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
    logic [BINS-1:0]       valid_reg;
    logic                  rdv_reg;
    logic [IDX_W-1:0]      idx_reg;

    // Range decode
    logic [7:0]      diff;
    logic [8:0]      span;
    logic [NB_W-1:0] nb;
    logic [7:0]      bin_val;

    // Accumulators
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [PR_W-1:0]       prod_reg;
    logic [TOT_W-1:0]      total_reg;
    logic [WS_W-1:0]       ws_reg;
    logic [COUNT_BITS-1:0] max_reg;

    // Median and modes
    logic [TOT_W:0]   cum_reg, cum_n, r1, r2;
    logic             f1_reg, f2_reg;
    logic [IDX_W-1:0] b1_reg, b2_reg, first_reg;
    logic [NB_W-1:0]  nm_reg, left_reg;
    logic             first_pend_reg;
    logic             is_mode;

    // Divider
    logic [TOT_W-1:0]  rem_reg;
    logic [TOT_W:0]    trial;
    logic [15:0]       lo_reg;
    logic [15:0]       q_reg;

    // Output register
    logic        ov_reg;
    logic [1:0]  kind_reg;
    logic        empty_reg;
    logic [21:0] tot_o_reg;
    logic [15:0] mean_reg;
    logic [8:0]  med_reg;
    logic [7:0]  mode_reg;
    logic        last_reg;
    logic [SAT_W-1:0] tot_wide;
    logic [21:0]      tot_sat;
    logic [7:0]       v1, v2;

    hse_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.bump),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Range decode and sample bin index
    always_comb
    begin
        diff = sample - range_low;
        span = {1'b0, range_high} - {1'b0, range_low} + 9'd1;
        if (range_high < range_low)
        begin
            nb = '0;
        end
        else if (span > 9'(BINS))
        begin
            nb = NB_W'(BINS);
        end
        else
        begin
            nb = span[NB_W-1:0];
        end
    end

    assign raddr   = cmd.rd_sample ? diff[IDX_W-1:0] : bin;
    assign cnt     = rdv_reg ? rdata : '0;
    assign wdata   = (&cnt) ? cnt : cnt + 1'b1;
    assign bin_val = range_low + 8'(bin);
    assign is_mode = (cnt == max_reg);
    assign cum_n   = cum_reg + (TOT_W+1)'(cnt);
    assign r1      = ({1'b0, total_reg} + 1'b1) >> 1;
    assign r2      = ({1'b0, total_reg} >> 1) + 1'b1;
    assign trial   = {rem_reg, lo_reg[15]};
    assign tot_wide = SAT_W'(total_reg);
    assign tot_sat  = (tot_wide > SAT_W'(hse_pkg::TOTAL_MAX)) ? hse_pkg::TOTAL_MAX
                                                               : tot_wide[21:0];
    assign v1 = range_low + 8'(b1_reg);
    assign v2 = range_low + 8'(b2_reg);

    // Status
    always_comb
    begin
        stat.in_range    = (sample >= range_low) && ({1'b0, diff} < 9'(nb));
        stat.nb_zero     = (nb == '0);
        stat.last_bin    = ((NB_W)'(bin) == nb - 1'b1);
        stat.total_zero  = (total_reg == '0);
        stat.single_mode = (nm_reg == NB_W'(1));
        stat.p3_emit     = is_mode && !first_pend_reg;
        stat.p3_last     = is_mode && !first_pend_reg && (left_reg == NB_W'(1));
        stat.out_free    = !ov_reg || out_ready;
    end

    // Valid bits for bins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            rdv_reg <= valid_reg[raddr];
            if (cmd.clear_bins)
            begin
                valid_reg <= '0;
            end
            else if (cmd.bump)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Walk accumulators, median search and divider
    always_ff @(posedge clk)
    begin
        if (cmd.rd_sample)
        begin
            idx_reg <= diff[IDX_W-1:0];
        end
        if (cmd.mul)
        begin
            cnt_reg  <= cnt;
            prod_reg <= cnt * bin_val;
        end
        if (cmd.clr_acc)
        begin
            total_reg <= '0;
            ws_reg    <= '0;
            max_reg   <= '0;
        end
        else if (cmd.acc1)
        begin
            total_reg <= total_reg + TOT_W'(cnt_reg);
            ws_reg    <= ws_reg + WS_W'(prod_reg);
            if (cnt_reg > max_reg)
            begin
                max_reg <= cnt_reg;
            end
        end
        if (cmd.rank_init)
        begin
            cum_reg <= '0;
            f1_reg  <= 1'b0;
            f2_reg  <= 1'b0;
            nm_reg  <= '0;
        end
        else if (cmd.acc2)
        begin
            cum_reg <= cum_n;
            if (!f1_reg && cum_n >= r1)
            begin
                f1_reg <= 1'b1;
                b1_reg <= bin;
            end
            if (!f2_reg && cum_n >= r2)
            begin
                f2_reg <= 1'b1;
                b2_reg <= bin;
            end
            if (is_mode)
            begin
                nm_reg <= nm_reg + 1'b1;
                if (nm_reg == '0)
                begin
                    first_reg <= bin;
                end
            end
        end
        // One quotient bit per cycle
        if (cmd.div_start)
        begin
            rem_reg <= ws_reg[WS_W-1:8];
            lo_reg  <= {ws_reg[7:0], 8'd0};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            lo_reg <= {lo_reg[14:0], 1'b0};
            if (trial >= {1'b0, total_reg})
            begin
                rem_reg <= TOT_W'(trial - {1'b0, total_reg});
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[TOT_W-1:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
        if (cmd.emit_sum)
        begin
            left_reg       <= nm_reg - 1'b1;
            first_pend_reg <= 1'b1;
        end
        else if (cmd.p3_step && is_mode)
        begin
            if (first_pend_reg)
            begin
                first_pend_reg <= 1'b0;
            end
            else
            begin
                left_reg <= left_reg - 1'b1;
            end
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.notice || cmd.emit_sum || (cmd.p3_step && stat.p3_emit))
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.notice)
        begin
            kind_reg  <= hse_pkg::KIND_NOTICE;
            empty_reg <= 1'b0;
            tot_o_reg <= '0;
            mean_reg  <= '0;
            med_reg   <= '0;
            mode_reg  <= '0;
            last_reg  <= 1'b1;
        end
        else if (cmd.emit_sum)
        begin
            kind_reg  <= hse_pkg::KIND_SUMMARY;
            empty_reg <= stat.total_zero;
            tot_o_reg <= tot_sat;
            if (stat.total_zero)
            begin
                mean_reg <= '0;
                med_reg  <= '0;
                mode_reg <= '0;
                last_reg <= 1'b1;
            end
            else
            begin
                mean_reg <= q_reg;
                med_reg  <= {1'b0, v1} + {1'b0, v2};
                mode_reg <= range_low + 8'(first_reg);
                last_reg <= stat.single_mode;
            end
        end
        else if (cmd.p3_step && stat.p3_emit)
        begin
            kind_reg  <= hse_pkg::KIND_MODE;
            empty_reg <= 1'b0;
            tot_o_reg <= '0;
            mean_reg  <= '0;
            med_reg   <= '0;
            mode_reg  <= bin_val;
            last_reg  <= stat.p3_last;
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = kind_reg;
    assign out_data  = {mode_reg, med_reg, mean_reg, tot_o_reg, empty_reg};
    assign out_last  = last_reg;

endmodule

[hw/rtl/histogram_statistics_engine_top.sv]
// Top level of the histogram statistics engine.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tdata sample, s_tlast end of set
// m_       out        m_tvalid / m_tready  m_tdata stats, m_tuser kind, m_tlast
// cfg      in         APB, pready high     range_low @0x0, range_high @0x4
//
// An in-range sample takes a bin memory read, then the saturating write back.
// A report walks the nb counted bins once to sum them (read, multiply, accumulate),
// again to locate the median and modes (read, accumulate), then runs the serial
// mean divider; with more than one mode, it rescans from bin zero up to the last mode.
// An empty set ends after the sum walk. All bins clear at once after a report.
// Reset clears the histogram and sets the range to 50..113.
// A stalled result holds the engine at the next result it would emit.

module histogram_statistics_engine_top #(
    parameter int BINS       = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // set_empty, total_count, mean_q8, median_twice, mode_value
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]         range_low_reg, range_high_reg;
    hse_pkg::hse_cmd_t  cmd;
    hse_pkg::hse_stat_t stat;
    logic [$clog2(BINS)-1:0] bin;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= hse_pkg::RANGE_LOW_RST;
            range_high_reg <= hse_pkg::RANGE_HIGH_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == hse_pkg::REG_RANGE_LOW)
            begin
                range_low_reg <= pwdata[7:0];
            end
            else
            begin
                range_high_reg <= pwdata[7:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = {24'd0, (paddr[2] == hse_pkg::REG_RANGE_HIGH) ? range_high_reg
                                                                   : range_low_reg};

    hse_ctrl #(
        .BINS (BINS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .bin      (bin)
    );

    hse_dp #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .sample     (s_tdata),
        .cmd        (cmd),
        .bin        (bin),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

[tb/sv/histogram_statistics_engine_top_tb.sv]
// Self-checking testbench for the histogram statistics engine top level.
`timescale 1ns / 1ps

module histogram_statistics_engine_top_tb;

    localparam int NBINS      = 64;
    localparam int CNT_MAX    = 65535;
    localparam int CYCLE_CAP  = 1000000;
    localparam int IDLE_WAIT  = 400;

    typedef struct packed {
        logic [7:0] sample;
        logic       eos;
    } sample_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        empty;
        logic [21:0] total;
        logic [15:0] mean;
        logic [8:0]  median;
        logic [7:0]  mode;
        logic        last;
    } stat_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    logic [7:0]  p_low;
    logic [7:0]  p_high;
    int unsigned p_bins [NBINS];

    sample_item_t pending_q[$];
    stat_item_t   stats_q[$];
    int           mismatches;
    int           results_seen;
    int           reports_seen;
    int           burst_left;
    int           gap_left;
    int           stall_phase;
    int           cycle_cnt;

    histogram_statistics_engine_top uut (.*);

    always #5 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL histogram_statistics_engine_top");
            $finish;
        end
    end

    function automatic int unsigned count_bins();
        int n;
        if (p_high < p_low)
            return 0;
        n = int'(p_high) - int'(p_low) + 1;
        return (n > NBINS) ? NBINS : n;
    endfunction

    function automatic int unsigned bin_of_rank(int unsigned nb, longint unsigned r);
        longint unsigned cum;
        cum = 0;
        for (int i = 0; i < nb; i++)
        begin
            cum += p_bins[i];
            if (cum >= r)
                return i;
        end
        return (nb != 0) ? nb - 1 : 0;
    endfunction

    // Work out the results one accepted item causes
    task automatic predict_stats(sample_item_t it);
        int unsigned     nb;
        int unsigned     idx;
        longint unsigned tot;
        longint unsigned wsum;
        int unsigned     maxc;
        int unsigned     med;
        logic [7:0]      modes[$];
        stat_item_t      r;
        nb = count_bins();
        r = '0;
        if (!it.eos)
        begin
            idx = int'(it.sample) - int'(p_low);
            if (it.sample >= p_low && idx < nb)
            begin
                if (p_bins[idx] < CNT_MAX)
                    p_bins[idx]++;
            end
            else
            begin
                r.kind = hse_pkg::KIND_NOTICE;
                r.last = 1'b1;
                stats_q.push_back(r);
            end
            return;
        end
        tot = 0;
        wsum = 0;
        maxc = 0;
        for (int i = 0; i < nb; i++)
        begin
            tot += p_bins[i];
            wsum += longint'(p_bins[i]) * (p_low + i);
            if (p_bins[i] > maxc)
                maxc = p_bins[i];
        end
        if (tot == 0)
        begin
            r.kind = hse_pkg::KIND_SUMMARY;
            r.empty = 1'b1;
            r.last = 1'b1;
            stats_q.push_back(r);
        end
        else
        begin
            if (tot[0])
                med = 2 * (p_low + bin_of_rank(nb, (tot + 1) / 2));
            else
                med = 2 * p_low + bin_of_rank(nb, tot / 2) + bin_of_rank(nb, tot / 2 + 1);
            for (int i = 0; i < nb; i++)
                if (p_bins[i] == maxc)
                    modes.push_back(p_low + i);
            r.kind = hse_pkg::KIND_SUMMARY;
            r.total = (tot > hse_pkg::TOTAL_MAX) ? hse_pkg::TOTAL_MAX : tot[21:0];
            r.mean = 16'((wsum * 256) / tot);
            r.median = med[8:0];
            r.mode = modes[0];
            r.last = (modes.size() == 1);
            stats_q.push_back(r);
            for (int j = 1; j < modes.size(); j++)
            begin
                r = '0;
                r.kind = hse_pkg::KIND_MODE;
                r.mode = modes[j];
                r.last = (j == modes.size() - 1);
                stats_q.push_back(r);
            end
        end
        for (int i = 0; i < NBINS; i++)
            p_bins[i] = 0;
    endtask

    // Driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_stats(pending_q.pop_front());
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_q[0].sample;
                    s_tlast <= pending_q[0].eos;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        stat_item_t got;
        stat_item_t exp;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 40)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 2) != 0);
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.empty = m_tdata[0];
                got.total = m_tdata[22:1];
                got.mean = m_tdata[38:23];
                got.median = m_tdata[47:39];
                got.mode = m_tdata[55:48];
                got.last = m_tlast;
                results_seen <= results_seen + 1;
                if (got.kind == hse_pkg::KIND_SUMMARY)
                    reports_seen <= reports_seen + 1;
                if (stats_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result kind=%0d mode=%0d", got.kind, got.mode);
                end
                else
                begin
                    exp = stats_q.pop_front();
                    if (got !== exp)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("mismatch exp k%0d e%0d t%0d m%0d md%0d mo%0d l%0d",
                                exp.kind, exp.empty, exp.total, exp.mean, exp.median,
                                exp.mode, exp.last);
                            $display("         got k%0d e%0d t%0d m%0d md%0d mo%0d l%0d",
                                got.kind, got.empty, got.total, got.mean, got.median,
                                got.mode, got.last);
                        end
                    end
                end
            end
        end
    end

    // Register write, block idle
    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == hse_pkg::REG_RANGE_LOW)
            p_low = val;
        else
            p_high = val;
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_tvalid || stats_q.size() > 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic add_item(logic [7:0] s, logic e);
        sample_item_t it;
        it.sample = s;
        it.eos = e;
        pending_q.push_back(it);
    endtask

    // Random set: mostly in-range samples, some noise, then end of set
    task automatic add_random_set(int len, int spread);
        int lo;
        lo = p_low;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_item(8'($urandom), 1'b0);
            else
                add_item(8'(lo + $urandom_range(0, spread)), 1'b0);
        end
        add_item(8'($urandom), 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        results_seen = 0;
        reports_seen = 0;
        cycle_cnt = 0;
        p_low = hse_pkg::RANGE_LOW_RST;
        p_high = hse_pkg::RANGE_HIGH_RST;
        for (int i = 0; i < NBINS; i++)
            p_bins[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty set, bounds, outside range, ties, odd and even median
        add_item(8'd0, 1'b1);
        add_item(8'd50, 1'b0);
        add_item(8'd113, 1'b0);
        add_item(8'd49, 1'b0);
        add_item(8'd114, 1'b0);
        add_item(8'd255, 1'b0);
        add_item(8'd0, 1'b0);
        add_item(8'd255, 1'b1);
        add_item(8'd60, 1'b0);
        add_item(8'd60, 1'b0);
        add_item(8'd70, 1'b0);
        add_item(8'd80, 1'b0);
        add_item(8'd80, 1'b0);
        add_item(8'd0, 1'b1);
        add_item(8'd61, 1'b0);
        add_item(8'd62, 1'b0);
        add_item(8'd90, 1'b1);
        wait_drained();

        // Full range 0..63, extremes
        write_reg(hse_pkg::REG_RANGE_LOW, 8'd0);
        write_reg(hse_pkg::REG_RANGE_HIGH, 8'd255);
        add_item(8'd0, 1'b0);
        add_item(8'd63, 1'b0);
        add_item(8'd64, 1'b0);
        add_item(8'd0, 1'b1);
        add_random_set(60, 63);
        wait_drained();

        // Top of the sample range, high clipped to 255
        write_reg(hse_pkg::REG_RANGE_LOW, 8'd255);
        add_item(8'd255, 1'b0);
        add_item(8'd254, 1'b0);
        add_item(8'd255, 1'b1);
        wait_drained();

        // Empty range: every sample is a notice
        write_reg(hse_pkg::REG_RANGE_LOW, 8'd200);
        write_reg(hse_pkg::REG_RANGE_HIGH, 8'd100);
        add_random_set(15, 255);
        wait_drained();

        // Random phases over several range settings, small spreads give ties
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(hse_pkg::REG_RANGE_LOW, 8'($urandom));
            write_reg(hse_pkg::REG_RANGE_HIGH, (ph == 0) ? 8'd255 : 8'($urandom));
            for (int s = 0; s < 4; s++)
                add_random_set($urandom_range(0, 20), $urandom_range(0, 70));
            wait_drained();
        end

        // Range changed mid-set
        write_reg(hse_pkg::REG_RANGE_LOW, 8'd20);
        write_reg(hse_pkg::REG_RANGE_HIGH, 8'd40);
        for (int i = 0; i < 12; i++)
            add_item(8'(20 + $urandom_range(0, 20)), 1'b0);
        wait_drained();
        write_reg(hse_pkg::REG_RANGE_LOW, 8'd25);
        add_item(8'd0, 1'b1);
        wait_drained();

        $display("covered %0d results, %0d summaries, range extremes, empty range, ties",
            results_seen, reports_seen);
        if (mismatches == 0)
            $display("PASS histogram_statistics_engine_top");
        else
            $display("FAIL histogram_statistics_engine_top");
        $finish;
    end

endmodule
